@@ design/clc_pkg.sv @@
// shared types, constants and helper functions of the segment clipper
`default_nettype none

package clc_pkg;

    localparam int COORD_BITS  = 16;
    localparam int DIV_STAGES  = 4;
    localparam int DIV_STEP    = COORD_BITS / DIV_STAGES;
    localparam int LANES       = 4;
    localparam int ADDR_BITS   = 4;
    localparam int DATA_BITS   = 32;
    localparam int IN_BITS     = 4 * COORD_BITS;
    localparam int OUT_BITS    = ((4 * COORD_BITS + 1 + 7) / 8) * 8;

    // register indexes on the configuration port
    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_TOP    = 2'd1;
    localparam logic [1:0] REG_RIGHT  = 2'd2;
    localparam logic [1:0] REG_BOTTOM = 2'd3;

    // lanes of the divider
    localparam int LANE_SX = 0;
    localparam int LANE_SY = 1;
    localparam int LANE_EX = 2;
    localparam int LANE_EY = 3;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [COORD_BITS+1:0] wide_t;
    typedef logic [COORD_BITS-1:0]        mag_t;
    typedef logic [2*COORD_BITS-1:0]      prod_t;

    typedef struct packed {
        coord_t left;
        coord_t top;
        coord_t right;
        coord_t bottom;
    } win_t;

    // first endpoint and direction, carried down the whole pipeline
    typedef struct packed {
        coord_t x1;
        coord_t y1;
        logic   sx;
        logic   sy;
        mag_t   mx;
        mag_t   my;
    } geo_t;

    // per axis: rejection, entering and leaving fractions
    typedef struct packed {
        logic rej;
        mag_t en_n;
        mag_t en_d;
        mag_t lv_n;
        mag_t lv_d;
    } axis_t;

    typedef struct packed {
        geo_t  g;
        axis_t ax;
        axis_t ay;
    } edge_t;

    typedef struct packed {
        mag_t rem;
        mag_t quo;
    } div_lane_t;

    typedef struct packed {
        geo_t                        g;
        logic                        vis;
        mag_t                        en_d;
        mag_t                        lv_d;
        div_lane_t [LANES-1:0]       ln;
    } div_t;

    // lower and upper edge of one axis, constraints -d*t <= qlo and d*t <= qhi
    function automatic axis_t axis_edges(input wide_t d, input wide_t qlo, input wide_t qhi);
        axis_t a;
        wide_t nlo;
        wide_t nhi;
        wide_t nd;
        a.rej  = 1'b0;
        a.en_n = '0;
        a.en_d = mag_t'(1);
        a.lv_n = mag_t'(1);
        a.lv_d = mag_t'(1);
        nlo = -qlo;
        nhi = -qhi;
        nd  = -d;
        if (d == '0) begin
            a.rej = (qlo < 0) || (qhi < 0);
        end else if (d > 0) begin
            if (qlo < 0) begin
                if (nlo > d) begin
                    a.rej = 1'b1;
                end else begin
                    a.en_n = nlo[COORD_BITS-1:0];
                    a.en_d = d[COORD_BITS-1:0];
                end
            end
            if (qhi < 0) begin
                a.rej = 1'b1;
            end else if (qhi < d) begin
                a.lv_n = qhi[COORD_BITS-1:0];
                a.lv_d = d[COORD_BITS-1:0];
            end
        end else begin
            if (qlo < 0) begin
                a.rej = 1'b1;
            end else if (qlo < nd) begin
                a.lv_n = qlo[COORD_BITS-1:0];
                a.lv_d = nd[COORD_BITS-1:0];
            end
            if (qhi < 0) begin
                if (nhi > nd) begin
                    a.rej = 1'b1;
                end else begin
                    a.en_n = nhi[COORD_BITS-1:0];
                    a.en_d = nd[COORD_BITS-1:0];
                end
            end
        end
        return a;
    endfunction

    // four restoring division steps, quotient bits shift in from the bottom
    function automatic div_lane_t div_step(input div_lane_t l, input mag_t den);
        div_lane_t       r;
        logic [COORD_BITS:0] t;
        r = l;
        for (int i = 0; i < DIV_STEP; i++) begin
            t = {r.rem, r.quo[COORD_BITS-1]};
            if (t >= {1'b0, den}) begin
                t     = t - {1'b0, den};
                r.quo = {r.quo[COORD_BITS-2:0], 1'b1};
            end else begin
                r.quo = {r.quo[COORD_BITS-2:0], 1'b0};
            end
            r.rem = t[COORD_BITS-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/clc_edge.sv @@
// first stage: direction, edge distances and per-edge fractions
`default_nettype none

module clc_edge (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire clc_pkg::coord_t start_x,
    input  wire clc_pkg::coord_t start_y,
    input  wire clc_pkg::coord_t end_x,
    input  wire clc_pkg::coord_t end_y,
    input  wire clc_pkg::win_t  win,
    output logic                out_valid,
    input  wire logic           out_ready,
    output clc_pkg::edge_t      out_data
);
    import clc_pkg::*;

    logic  valid_reg;
    edge_t data_reg;
    edge_t data_next;
    wide_t dx;
    wide_t dy;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        dx = wide_t'(end_x) - wide_t'(start_x);
        dy = wide_t'(end_y) - wide_t'(start_y);
        data_next.g.x1 = start_x;
        data_next.g.y1 = start_y;
        data_next.g.sx = dx[COORD_BITS+1];
        data_next.g.sy = dy[COORD_BITS+1];
        data_next.g.mx = dx[COORD_BITS+1] ? mag_t'(-dx) : mag_t'(dx);
        data_next.g.my = dy[COORD_BITS+1] ? mag_t'(-dy) : mag_t'(dy);
        data_next.ax = axis_edges(dx, wide_t'(start_x) - wide_t'(win.left),
                                  wide_t'(win.right) - wide_t'(start_x));
        data_next.ay = axis_edges(dy, wide_t'(start_y) - wide_t'(win.top),
                                  wide_t'(win.bottom) - wide_t'(start_y));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

@@ design/clc_tsel.sv @@
// t_enter / t_exit selection and the visibility test, four stages
`default_nettype none

module clc_tsel (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire clc_pkg::edge_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output clc_pkg::div_t       out_data
);
    import clc_pkg::*;

    logic [3:0] v_reg;
    logic [4:0] rdy;

    // stage b: cross products of the candidates
    geo_t  b_g_reg;
    logic  b_rej_reg;
    axis_t b_ax_reg, b_ay_reg;
    prod_t b_pex_reg, b_pey_reg, b_plx_reg, b_ply_reg;
    // stage c: chosen fractions
    geo_t  c_g_reg;
    logic  c_rej_reg;
    mag_t  c_en_n_reg, c_en_d_reg, c_lv_n_reg, c_lv_d_reg;
    // stage d: products for the test and the dividends
    geo_t  d_g_reg;
    logic  d_rej_reg;
    mag_t  d_en_d_reg, d_lv_d_reg;
    prod_t d_pa_reg, d_pb_reg;
    prod_t d_dv_reg [LANES];
    // stage e: division input
    div_t  e_reg;
    div_t  e_next;

    // ready ripples back from the output, so walk the stages last to first
    always_comb begin
        rdy[4] = out_ready;
        for (int k = 3; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[3];
    assign out_data  = e_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) v_reg[0] <= in_valid;
            if (rdy[1]) v_reg[1] <= v_reg[0];
            if (rdy[2]) v_reg[2] <= v_reg[1];
            if (rdy[3]) v_reg[3] <= v_reg[2];
        end
    end

    always_comb begin
        e_next.g    = d_g_reg;
        e_next.vis  = !d_rej_reg && !(d_pa_reg > d_pb_reg);
        e_next.en_d = d_en_d_reg;
        e_next.lv_d = d_lv_d_reg;
        for (int l = 0; l < LANES; l++) begin
            e_next.ln[l].rem = d_dv_reg[l][2*COORD_BITS-1:COORD_BITS];
            e_next.ln[l].quo = d_dv_reg[l][COORD_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            b_g_reg   <= in_data.g;
            b_rej_reg <= in_data.ax.rej || in_data.ay.rej;
            b_ax_reg  <= in_data.ax;
            b_ay_reg  <= in_data.ay;
            b_pex_reg <= in_data.ax.en_n * in_data.ay.en_d;
            b_pey_reg <= in_data.ay.en_n * in_data.ax.en_d;
            b_plx_reg <= in_data.ax.lv_n * in_data.ay.lv_d;
            b_ply_reg <= in_data.ay.lv_n * in_data.ax.lv_d;
        end
        if (rdy[1]) begin
            c_g_reg   <= b_g_reg;
            c_rej_reg <= b_rej_reg;
            // the y edge wins only when strictly later on entry, earlier on exit
            if (b_pey_reg > b_pex_reg) begin
                c_en_n_reg <= b_ay_reg.en_n;
                c_en_d_reg <= b_ay_reg.en_d;
            end else begin
                c_en_n_reg <= b_ax_reg.en_n;
                c_en_d_reg <= b_ax_reg.en_d;
            end
            if (b_ply_reg < b_plx_reg) begin
                c_lv_n_reg <= b_ay_reg.lv_n;
                c_lv_d_reg <= b_ay_reg.lv_d;
            end else begin
                c_lv_n_reg <= b_ax_reg.lv_n;
                c_lv_d_reg <= b_ax_reg.lv_d;
            end
        end
        if (rdy[2]) begin
            d_g_reg    <= c_g_reg;
            d_rej_reg  <= c_rej_reg;
            d_en_d_reg <= c_en_d_reg;
            d_lv_d_reg <= c_lv_d_reg;
            d_pa_reg   <= c_en_n_reg * c_lv_d_reg;
            d_pb_reg   <= c_lv_n_reg * c_en_d_reg;
            d_dv_reg[LANE_SX] <= c_g_reg.mx * c_en_n_reg;
            d_dv_reg[LANE_SY] <= c_g_reg.my * c_en_n_reg;
            d_dv_reg[LANE_EX] <= c_g_reg.mx * c_lv_n_reg;
            d_dv_reg[LANE_EY] <= c_g_reg.my * c_lv_n_reg;
        end
        if (rdy[3]) begin
            e_reg <= e_next;
        end
    end

endmodule

`default_nettype wire

@@ design/clc_div.sv @@
// four-lane pipelined restoring divider, four quotient bits per stage
`default_nettype none

module clc_div (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire clc_pkg::div_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output clc_pkg::div_t      out_data
);
    import clc_pkg::*;

    logic [DIV_STAGES-1:0] v_reg;
    logic [DIV_STAGES:0]   rdy;
    logic [DIV_STAGES-1:0] src_v;
    div_t st_reg [DIV_STAGES];
    div_t src    [DIV_STAGES];
    div_t st_next[DIV_STAGES];

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[DIV_STAGES-1];
    assign out_data  = st_reg[DIV_STAGES-1];

    always_comb begin
        rdy[DIV_STAGES] = out_ready;
        for (int s = DIV_STAGES - 1; s >= 0; s--) begin
            rdy[s] = !v_reg[s] || rdy[s+1];
        end
        src[0]   = in_data;
        src_v[0] = in_valid;
        for (int s = 1; s < DIV_STAGES; s++) begin
            src[s]   = st_reg[s-1];
            src_v[s] = v_reg[s-1];
        end
        for (int s = 0; s < DIV_STAGES; s++) begin
            st_next[s] = src[s];
            st_next[s].ln[LANE_SX] = div_step(src[s].ln[LANE_SX], src[s].en_d);
            st_next[s].ln[LANE_SY] = div_step(src[s].ln[LANE_SY], src[s].en_d);
            st_next[s].ln[LANE_EX] = div_step(src[s].ln[LANE_EX], src[s].lv_d);
            st_next[s].ln[LANE_EY] = div_step(src[s].ln[LANE_EY], src[s].lv_d);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                if (rdy[s]) v_reg[s] <= src_v[s];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (rdy[s]) st_reg[s] <= st_next[s];
        end
    end

endmodule

`default_nettype wire

@@ design/line_segment_rect_clipper.sv @@
// Clips one segment per transaction against the configured window (Liang-Barsky form of
// Cyrus-Beck, exact fractions, coordinates truncated toward zero). One segment is accepted
// every cycle while m_tready does not stall it; each result passes one edge stage,
// four stages of fraction selection and the visibility test, four stages of the four-lane
// divider (four quotient bits each) and the output register. The user must write the window
// registers over the APB port only while no segment is in flight; this is not enforced.
`default_nettype none

module line_segment_rect_clipper (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // start_x, start_y, end_x, end_y
    input  wire logic [clc_pkg::IN_BITS-1:0] s_tdata,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // visible, clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y, zero pad
    output logic [clc_pkg::OUT_BITS-1:0]     m_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [clc_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [clc_pkg::DATA_BITS-1:0] pwdata,
    output logic [clc_pkg::DATA_BITS-1:0]    prdata,
    output logic                             pready
);
    import clc_pkg::*;

    win_t  win_reg;
    logic  [1:0] idx;
    coord_t rd_val;
    logic  e_valid, e_ready, t_valid, t_ready, d_valid, d_ready;
    edge_t e_data;
    div_t  t_data, d_data;
    logic  o_valid_reg;
    logic  [OUT_BITS-1:0] o_data_reg;
    logic  [OUT_BITS-1:0] o_data_next;
    coord_t c_out [LANES];
    logic   signed [COORD_BITS:0] base;
    coord_t org;
    logic   neg;

    // configuration
    assign pready = 1'b1;
    assign idx    = paddr[3:2];

    always_comb begin
        case (idx)
            REG_LEFT:   rd_val = win_reg.left;
            REG_TOP:    rd_val = win_reg.top;
            REG_RIGHT:  rd_val = win_reg.right;
            REG_BOTTOM: rd_val = win_reg.bottom;
            default:    rd_val = '0;
        endcase
        prdata = DATA_BITS'(signed'(rd_val));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg.left   <= coord_t'(0);
            win_reg.top    <= coord_t'(0);
            win_reg.right  <= coord_t'(639);
            win_reg.bottom <= coord_t'(479);
        end else if (psel && penable && pwrite && pready) begin
            case (idx)
                REG_LEFT:   win_reg.left   <= pwdata[COORD_BITS-1:0];
                REG_TOP:    win_reg.top    <= pwdata[COORD_BITS-1:0];
                REG_RIGHT:  win_reg.right  <= pwdata[COORD_BITS-1:0];
                REG_BOTTOM: win_reg.bottom <= pwdata[COORD_BITS-1:0];
                default:    ;
            endcase
        end
    end

    clc_edge u_edge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .start_x   (s_tdata[COORD_BITS-1:0]),
        .start_y   (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .end_x     (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .end_y     (s_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .win       (win_reg),
        .out_valid (e_valid),
        .out_ready (e_ready),
        .out_data  (e_data)
    );

    clc_tsel u_tsel (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (e_valid),
        .in_ready  (e_ready),
        .in_data   (e_data),
        .out_valid (t_valid),
        .out_ready (t_ready),
        .out_data  (t_data)
    );

    clc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (t_valid),
        .in_ready  (t_ready),
        .in_data   (t_data),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_data  (d_data)
    );

    // p1 + d*t, rounded toward zero from the quotient and the remainder
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (l == LANE_SX || l == LANE_EX) begin
                org = d_data.g.x1;
                neg = d_data.g.sx;
            end else begin
                org = d_data.g.y1;
                neg = d_data.g.sy;
            end
            if (!neg) begin
                base = (COORD_BITS+1)'(org) + signed'({1'b0, d_data.ln[l].quo});
                if (d_data.ln[l].rem != '0 && base < 0) begin
                    base = base + (COORD_BITS+1)'(1);
                end
            end else begin
                base = (COORD_BITS+1)'(org) - signed'({1'b0, d_data.ln[l].quo});
                if (d_data.ln[l].rem != '0 && base > 0) begin
                    base = base - (COORD_BITS+1)'(1);
                end
            end
            c_out[l] = d_data.vis ? base[COORD_BITS-1:0] : coord_t'(0);
        end
        o_data_next = OUT_BITS'({c_out[LANE_EY], c_out[LANE_EX], c_out[LANE_SY],
                                 c_out[LANE_SX], d_data.vis});
    end

    assign d_ready  = !o_valid_reg || m_tready;
    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (d_ready) begin
            o_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (d_ready) begin
            o_data_reg <= o_data_next;
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/tb_line_segment_rect_clipper.sv @@
// testbench for the segment clipper: directed table plus random segments, checked against a predictor
`timescale 1ns / 100ps

module tb_line_segment_rect_clipper;
    import clc_pkg::*;

    typedef struct packed {
        logic   visible;
        coord_t csx;
        coord_t csy;
        coord_t cex;
        coord_t cey;
    } clip_res_t;

    typedef struct {
        coord_t    sx;
        coord_t    sy;
        coord_t    ex;
        coord_t    ey;
        logic      known;
        clip_res_t res;
    } seg_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic [IN_BITS-1:0]    s_tdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [OUT_BITS-1:0]   m_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_BITS-1:0]  paddr;
    logic [DATA_BITS-1:0]  pwdata;
    logic [DATA_BITS-1:0]  prdata;
    logic                  pready;

    line_segment_rect_clipper DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // window copy held by the predictor
    longint win_left, win_top, win_right, win_bottom;

    clip_res_t expected_clips[$];
    int        fails;
    int        n_segs;
    int        n_visible;
    int        send_idle;
    int        recv_idle;
    int        stall_cycles;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // edge update on exact fractions; returns 0 on rejection
    function automatic bit clip_edge(input longint p, input longint q,
                                     inout longint en, inout longint ed,
                                     inout longint xn, inout longint xd);
        if (p == 0) return q >= 0;
        if (p < 0) begin
            if (-q <= 0) return 1;
            if (-q > -p) return 0;
            if ((-q) * ed > en * (-p)) begin
                en = -q;
                ed = -p;
            end
        end else begin
            if (q < 0) return 0;
            if (q >= p) return 1;
            if (q * xd < xn * p) begin
                xn = q;
                xd = p;
            end
        end
        return 1;
    endfunction

    // x1 + d*num/den truncated toward zero
    function automatic coord_t point_at(input longint x1, input longint d,
                                        input longint num, input longint den);
        longint prod, quo, rem, v;
        prod = (d < 0 ? -d : d) * num;
        quo  = prod / den;
        rem  = prod % den;
        if (d >= 0) begin
            v = x1 + quo;
            if (rem != 0 && v < 0) v = v + 1;
        end else begin
            v = x1 - quo;
            if (rem != 0 && v >= 1) v = v - 1;
        end
        return coord_t'(v);
    endfunction

    function automatic clip_res_t clip_segment(input coord_t sx, input coord_t sy,
                                               input coord_t ex, input coord_t ey);
        clip_res_t r;
        longint x1, y1, dx, dy, en, ed, xn, xd;
        bit vis;
        x1 = sx; y1 = sy;
        dx = longint'(ex) - x1;
        dy = longint'(ey) - y1;
        en = 0; ed = 1; xn = 1; xd = 1;
        r = '0;
        vis = clip_edge(-dx, x1 - win_left, en, ed, xn, xd);
        if (vis) vis = clip_edge(dx, win_right - x1, en, ed, xn, xd);
        if (vis) vis = clip_edge(-dy, y1 - win_top, en, ed, xn, xd);
        if (vis) vis = clip_edge(dy, win_bottom - y1, en, ed, xn, xd);
        if (vis && en * xd > xn * ed) vis = 0;
        if (vis) begin
            r.visible = 1'b1;
            r.csx = point_at(x1, dx, en, ed);
            r.csy = point_at(y1, dy, en, ed);
            r.cex = point_at(x1, dx, xn, xd);
            r.cey = point_at(y1, dy, xn, xd);
        end
        return r;
    endfunction

    task automatic write_window(input logic [1:0] idx, input coord_t v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'(4 * idx);
        pwdata  <= DATA_BITS'(signed'(v));
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_LEFT:   win_left   = v;
            REG_TOP:    win_top    = v;
            REG_RIGHT:  win_right  = v;
            default:    win_bottom = v;
        endcase
    endtask

    task automatic set_window(input coord_t l, input coord_t t, input coord_t r,
                              input coord_t b);
        write_window(REG_LEFT, l);
        write_window(REG_TOP, t);
        write_window(REG_RIGHT, r);
        write_window(REG_BOTTOM, b);
    endtask

    task automatic send_segment(input coord_t sx, input coord_t sy, input coord_t ex,
                                input coord_t ey, input logic known, input clip_res_t res);
        clip_res_t pred;
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= {ey, ex, sy, sx};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred = clip_segment(sx, sy, ex, ey);
        if (known && pred !== res)
            $display("%0t: table row disagrees with predictor: exp %h pred %h",
                     $time, res, pred);
        expected_clips.push_back(known ? res : pred);
        n_segs++;
        if (pred.visible) n_visible++;
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (expected_clips.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    function automatic coord_t rand_coord(input int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'(int'($urandom_range(800)) - 80);
            default: return coord_t'(($urandom_range(1) ? 32767 : -32768)
                                     - $urandom_range(3) * ($urandom_range(1) ? 1 : -1));
        endcase
    endfunction

    // result side: receiver stalls and field checks
    always @(posedge aclk) begin
        clip_res_t got, exp_r;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.visible = m_tdata[0];
                got.csx     = m_tdata[COORD_BITS:1];
                got.csy     = m_tdata[2*COORD_BITS:COORD_BITS+1];
                got.cex     = m_tdata[3*COORD_BITS:2*COORD_BITS+1];
                got.cey     = m_tdata[4*COORD_BITS:3*COORD_BITS+1];
                stall_cycles <= 0;
                if (expected_clips.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    fails++;
                end else begin
                    exp_r = expected_clips.pop_front();
                    if (got.visible !== exp_r.visible || got.csx !== exp_r.csx ||
                        got.csy !== exp_r.csy || got.cex !== exp_r.cex ||
                        got.cey !== exp_r.cey) begin
                        $display("%0t: expected %b %0d %0d %0d %0d actual %b %0d %0d %0d %0d",
                                 $time, exp_r.visible, exp_r.csx, exp_r.csy, exp_r.cex,
                                 exp_r.cey, got.visible, got.csx, got.csy, got.cex, got.cey);
                        fails++;
                    end
                end
            end else if (s_tvalid && s_tready) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge aclk) begin
        if (stall_cycles > 5000) begin
            $display("line_segment_rect_clipper: mismatch");
            $finish;
        end
    end

    seg_row_t dir_rows[$];

    function automatic seg_row_t row(input int sx, input int sy, input int ex, input int ey,
                                     input logic known, input clip_res_t res);
        seg_row_t r;
        r.sx = coord_t'(sx); r.sy = coord_t'(sy); r.ex = coord_t'(ex); r.ey = coord_t'(ey);
        r.known = known; r.res = res;
        return r;
    endfunction

    initial begin
        clip_res_t none;
        int mode;
        none = '0;
        fails = 0; n_segs = 0; n_visible = 0; stall_cycles = 0;
        send_idle = 16; recv_idle = 61;
        aresetn = 1'b0; s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        win_left = 0; win_top = 0; win_right = 639; win_bottom = 479;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset window, inside, crossing, parallel outside, point, extremes
        dir_rows.push_back(row(10, 20, 30, 40, 1, '{1'b1, 10, 20, 30, 40}));
        dir_rows.push_back(row(-100, 100, 700, 100, 1, '{1'b1, 0, 100, 639, 100}));
        dir_rows.push_back(row(-5, 10, -5, 300, 1, none));
        dir_rows.push_back(row(0, 0, 0, 0, 1, '{1'b1, 0, 0, 0, 0}));
        dir_rows.push_back(row(639, 479, 639, 479, 1, '{1'b1, 639, 479, 639, 479}));
        dir_rows.push_back(row(640, 0, 640, 0, 1, none));
        dir_rows.push_back(row(-32768, -32768, 32767, 32767, 0, none));
        dir_rows.push_back(row(32767, -32768, -32768, 32767, 0, none));
        dir_rows.push_back(row(-32768, 240, 32767, 240, 1, '{1'b1, 0, 240, 639, 240}));
        dir_rows.push_back(row(700, 100, -100, 100, 1, '{1'b1, 639, 100, 0, 100}));
        dir_rows.push_back(row(-10, -10, -1, 500, 1, none));
        dir_rows.push_back(row(-1, 0, 1, 3, 0, none));
        dir_rows.push_back(row(639, -3, 645, 3, 0, none));
        dir_rows.push_back(row(-1, -1, -32768, 32767, 1, none));
        foreach (dir_rows[i])
            send_segment(dir_rows[i].sx, dir_rows[i].sy, dir_rows[i].ex, dir_rows[i].ey,
                         dir_rows[i].known, dir_rows[i].res);
        drain();

        // extreme and degenerate windows
        set_window(-32768, -32768, 32767, 32767);
        send_segment(-32768, -32768, 32767, 32767, 1, '{1'b1, -32768, -32768, 32767, 32767});
        send_segment(32767, 5, -32768, -5, 0, none);
        drain();
        set_window(5, 5, 5, 5);
        send_segment(0, 0, 10, 10, 1, '{1'b1, 5, 5, 5, 5});
        send_segment(0, 5, 10, 5, 1, '{1'b1, 5, 5, 5, 5});
        send_segment(0, 0, 10, 9, 1, none);
        drain();
        set_window(10, 0, 9, 100);
        send_segment(0, 50, 20, 50, 1, none);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 2) begin send_idle = 61; recv_idle = 16; end
            if (phase == 4) begin send_idle = 0;  recv_idle = 0;  end
            case (phase % 3)
                0: set_window(0, 0, 639, 479);
                1: set_window(-32768, -200, 32767, 200);
                default: set_window(coord_t'(int'($urandom_range(100)) - 50),
                                    coord_t'(int'($urandom_range(100)) - 50),
                                    coord_t'(int'($urandom_range(700)) + 50),
                                    coord_t'(int'($urandom_range(500)) + 50));
            endcase
            for (int k = 0; k < 325; k++) begin
                mode = $urandom_range(9) < 6 ? 1 : ($urandom_range(3) == 0 ? 2 : 0);
                send_segment(rand_coord(mode), rand_coord(mode),
                             rand_coord(mode), rand_coord(mode), 0, none);
            end
            drain();
        end

        $display("segments checked: %0d, visible: %0d, across reset, extreme,",
                 n_segs, n_visible);
        $display("point-sized, inverted and random windows under both stall patterns");
        if (fails == 0)
            $display("line_segment_rect_clipper: match");
        else
            $display("line_segment_rect_clipper: mismatch");
        $finish;
    end
endmodule

@@ filelist.f @@
design/clc_pkg.sv
design/clc_edge.sv
design/clc_tsel.sv
design/clc_div.sv
design/line_segment_rect_clipper.sv
tb/sv/tb_line_segment_rect_clipper.sv
